### rtl/rvx_pkg.sv
// Package for the ray/voxel exit intersection pipeline.
// Shared constants and the per-axis flag bundle; no dependencies.
package rvx_pkg;

  localparam int FRAC_BITS_DEF   = 16;
  localparam int INDEX_WIDTH_DEF = 10;
  localparam int VOXEL_W         = 10;
  localparam int DATA_W          = 32;
  localparam int DIST_W          = 31;
  localparam int DIV_STEPS       = DIST_W;
  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  // per-axis flags computed up front and carried along the divider
  typedef struct packed {
    logic dir_nz;
    logic dneg;
    logic num_neg;
    logic idx_nz;
    logic sat;
  } axis_flags_t;

endpackage

### rtl/ray_voxel_exit_intersect.sv
// Ray exit from a unit voxel: fully pipelined, one transaction per cycle.
// Stages: input stage, 31 one-bit divider stages, product stage and
// output register. Throughput: one transaction per cycle; the 31-stage
// restoring divider sets the depth. The whole pipe holds while out_stall
// blocks a full output register. Synchronous active-low reset clears valids.
module ray_voxel_exit_intersect #(
  parameter int FRAC_BITS   = rvx_pkg::FRAC_BITS_DEF,
  parameter int INDEX_WIDTH = rvx_pkg::INDEX_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [rvx_pkg::VOXEL_W-1:0]       in_voxel_x,
  input  logic [rvx_pkg::VOXEL_W-1:0]       in_voxel_y,
  input  logic [rvx_pkg::VOXEL_W-1:0]       in_voxel_z,
  input  logic signed [rvx_pkg::DATA_W-1:0] in_origin_x,
  input  logic signed [rvx_pkg::DATA_W-1:0] in_origin_y,
  input  logic signed [rvx_pkg::DATA_W-1:0] in_origin_z,
  input  logic signed [rvx_pkg::DATA_W-1:0] in_dir_x,
  input  logic signed [rvx_pkg::DATA_W-1:0] in_dir_y,
  input  logic signed [rvx_pkg::DATA_W-1:0] in_dir_z,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_hit,
  output logic [rvx_pkg::DIST_W-1:0]        out_distance
);
  import rvx_pkg::*;

  localparam int RW = ((INDEX_WIDTH + FRAC_BITS + 1 > DATA_W) ?
                       INDEX_WIDTH + FRAC_BITS + 1 : DATA_W) + 1;
  localparam int DS = DIV_STEPS;

  logic adv;
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  logic [VOXEL_W-1:0]        vox [3];
  logic signed [DATA_W-1:0]  org [3];
  logic signed [DATA_W-1:0]  dir [3];

  assign vox = '{in_voxel_x, in_voxel_y, in_voxel_z};
  assign org = '{in_origin_x, in_origin_y, in_origin_z};
  assign dir = '{in_dir_x, in_dir_y, in_dir_z};

  logic [DATA_W-1:0]         rem_w [DS+1][3];
  logic [DIST_W-1:0]         lo_w  [DS+1][3];
  logic [DIST_W-1:0]         quo_w [DS+1][3];
  logic [DATA_W-1:0]         den_w [DS+1][3];
  logic signed [RW-1:0]      rel_r [DS+1][3];
  logic signed [DATA_W-1:0]  dir_r [DS+1][3];
  axis_flags_t               flg_r [DS+1][3];
  logic                      v_r   [DS+1];

  rvx_prep #(
    .FRAC_BITS   (FRAC_BITS),
    .INDEX_WIDTH (INDEX_WIDTH),
    .RW          (RW)
  ) u_prep (
    .clk   (clk),
    .en    (adv),
    .vox   (vox),
    .org   (org),
    .dir   (dir),
    .rem_o (rem_w[0]),
    .lo_o  (lo_w[0]),
    .den_o (den_w[0]),
    .rel_o (rel_r[0]),
    .dir_o (dir_r[0]),
    .flg_o (flg_r[0])
  );

  for (genvar a = 0; a < 3; a++) begin : g_q0
    assign quo_w[0][a] = '0;
  end

  for (genvar s = 0; s < DS; s++) begin : g_div
    for (genvar a = 0; a < 3; a++) begin : g_lane
      rvx_div_step u_step (
        .clk   (clk),
        .en    (adv),
        .rem_i (rem_w[s][a]),
        .lo_i  (lo_w[s][a]),
        .quo_i (quo_w[s][a]),
        .den_i (den_w[s][a]),
        .rem_o (rem_w[s+1][a]),
        .lo_o  (lo_w[s+1][a]),
        .quo_o (quo_w[s+1][a]),
        .den_o (den_w[s+1][a])
      );
    end

    // side data rides alongside the divider
    always_ff @(posedge clk) begin
      if (adv) begin
        rel_r[s+1] <= rel_r[s];
        dir_r[s+1] <= dir_r[s];
        flg_r[s+1] <= flg_r[s];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= DS; i++) begin
        v_r[i] <= 1'b0;
      end
    end else if (adv) begin
      v_r[0] <= in_valid;
      for (int i = 1; i <= DS; i++) begin
        v_r[i] <= v_r[i-1];
      end
    end
  end

  rvx_check #(
    .FRAC_BITS (FRAC_BITS),
    .RW        (RW)
  ) u_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (adv),
    .valid_i      (v_r[DS]),
    .quo_i        (quo_w[DS]),
    .rel_i        (rel_r[DS]),
    .dir_i        (dir_r[DS]),
    .flg_i        (flg_r[DS]),
    .out_valid    (out_valid),
    .out_hit      (out_hit),
    .out_distance (out_distance)
  );

endmodule

### rtl/rvx_prep.sv
// Input stage: relative position, face numerator, magnitudes and divider seed.
// Depends on rvx_pkg.
module rvx_prep #(
  parameter int FRAC_BITS   = 16,
  parameter int INDEX_WIDTH = 10,
  parameter int RW          = 33
) (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic [rvx_pkg::VOXEL_W-1:0]          vox   [3],
  input  logic signed [rvx_pkg::DATA_W-1:0]    org   [3],
  input  logic signed [rvx_pkg::DATA_W-1:0]    dir   [3],
  output logic [rvx_pkg::DATA_W-1:0]           rem_o [3],
  output logic [rvx_pkg::DIST_W-1:0]           lo_o  [3],
  output logic [rvx_pkg::DATA_W-1:0]           den_o [3],
  output logic signed [RW-1:0]                 rel_o [3],
  output logic signed [rvx_pkg::DATA_W-1:0]    dir_o [3],
  output rvx_pkg::axis_flags_t                 flg_o [3]
);
  import rvx_pkg::*;

  localparam int NW = RW + 1;
  localparam int DW = NW + FRAC_BITS;
  localparam logic signed [NW-1:0] HALF = NW'(64'd1 << (FRAC_BITS - 1));

  for (genvar a = 0; a < 3; a++) begin : g_axis
    logic [INDEX_WIDTH-1:0] idx;
    logic [RW-1:0]          idx_ext;
    logic signed [RW-1:0]   rel;
    logic signed [NW-1:0]   num;
    logic [NW-1:0]          nmag;
    logic [DATA_W-1:0]      dmag;
    logic [DW-1:0]          dv;
    logic                   dneg;
    logic                   sat;

    always_comb begin
      idx     = INDEX_WIDTH'(vox[a]);
      idx_ext = RW'({idx, FRAC_BITS'(0)});
      rel     = RW'(org[a]) - $signed(idx_ext);
      dneg    = dir[a][DATA_W-1];
      num     = dneg ? (-HALF - NW'(rel)) : (HALF - NW'(rel));
      nmag    = num[NW-1] ? NW'(-num) : NW'(num);
      dmag    = dneg ? DATA_W'(-dir[a]) : DATA_W'(dir[a]);
      // quotient reaches 2^31 exactly when nmag >= dmag * 2^(31-F)
      sat     = 64'(nmag) >= (64'(dmag) << (DIST_W - FRAC_BITS));
      dv      = {nmag, FRAC_BITS'(0)};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_o[a] <= sat ? '0 : DATA_W'(dv >> DIST_W);
        lo_o[a]  <= dv[DIST_W-1:0];
        den_o[a] <= dmag;
        rel_o[a] <= rel;
        dir_o[a] <= dir[a];
        flg_o[a] <= '{dir_nz:  (dir[a] != '0),
                      dneg:    dneg,
                      num_neg: num[NW-1],
                      idx_nz:  (idx != '0),
                      sat:     sat};
      end
    end
  end

endmodule

### rtl/rvx_div_step.sv
// One restoring-division step: produces one quotient bit per stage.
// Depends on rvx_pkg.
module rvx_div_step (
  input  logic                         clk,
  input  logic                         en,
  input  logic [rvx_pkg::DATA_W-1:0]   rem_i,
  input  logic [rvx_pkg::DIST_W-1:0]   lo_i,
  input  logic [rvx_pkg::DIST_W-1:0]   quo_i,
  input  logic [rvx_pkg::DATA_W-1:0]   den_i,
  output logic [rvx_pkg::DATA_W-1:0]   rem_o,
  output logic [rvx_pkg::DIST_W-1:0]   lo_o,
  output logic [rvx_pkg::DIST_W-1:0]   quo_o,
  output logic [rvx_pkg::DATA_W-1:0]   den_o
);
  import rvx_pkg::*;

  logic [DATA_W:0]   sh;
  logic [DATA_W:0]   diff;
  logic              qbit;
  logic [DATA_W-1:0] rem_nxt;

  always_comb begin
    sh      = {rem_i, lo_i[DIST_W-1]};
    diff    = sh - {1'b0, den_i};
    qbit    = (sh >= {1'b0, den_i});
    rem_nxt = qbit ? diff[DATA_W-1:0] : sh[DATA_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_o <= rem_nxt;
      lo_o  <= {lo_i[DIST_W-2:0], 1'b0};
      quo_o <= {quo_i[DIST_W-2:0], qbit};
      den_o <= den_i;
    end
  end

endmodule

### rtl/rvx_check.sv
// Back end: distance rule, exit-point products, box test and axis priority.
// Two register stages; the second is the output register. Depends on rvx_pkg.
module rvx_check #(
  parameter int FRAC_BITS = 16,
  parameter int RW        = 33
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               en,
  input  logic                               valid_i,
  input  logic [rvx_pkg::DIST_W-1:0]         quo_i [3],
  input  logic signed [RW-1:0]               rel_i [3],
  input  logic signed [rvx_pkg::DATA_W-1:0]  dir_i [3],
  input  rvx_pkg::axis_flags_t               flg_i [3],
  output logic                               out_valid,
  output logic                               out_hit,
  output logic [rvx_pkg::DIST_W-1:0]         out_distance
);
  import rvx_pkg::*;

  localparam int PW = 2 * DATA_W;
  localparam int UW = ((RW > PW - FRAC_BITS) ? RW : PW - FRAC_BITS) + 1;
  localparam logic signed [UW-1:0] HALF = UW'(64'd1 << (FRAC_BITS - 1));

  logic                   v1_r;
  logic [DIST_W-1:0]      t_r    [3];
  logic                   ok_r   [3];
  logic signed [PW-1:0]   prod_r [3][2];
  logic signed [RW-1:0]   rel_r  [3];
  logic                   nz_r   [3];

  // stage 1: saturate, distance rule, two products per axis
  for (genvar a = 0; a < 3; a++) begin : g_s1
    logic [DIST_W-1:0] tq;
    logic              tneg;
    logic              ok;

    always_comb begin
      tq   = flg_i[a].sat ? DIST_MAX : quo_i[a];
      tneg = (tq != '0) && (flg_i[a].num_neg != flg_i[a].dneg);
      ok   = flg_i[a].dir_nz && !tneg &&
             ((flg_i[a].dneg && flg_i[a].idx_nz) || (tq != '0));
    end

    always_ff @(posedge clk) begin
      if (en) begin
        t_r[a]       <= tq;
        ok_r[a]      <= ok;
        prod_r[a][0] <= $signed({1'b0, tq}) * dir_i[(a + 1) % 3];
        prod_r[a][1] <= $signed({1'b0, tq}) * dir_i[(a + 2) % 3];
        rel_r[a]     <= rel_i[a];
        nz_r[a]      <= flg_i[a].idx_nz;
      end
    end
  end

  // stage 2: coordinates on the face, box test, first passing axis
  logic in_box [3][2];
  logic pass   [3];

  for (genvar a = 0; a < 3; a++) begin : g_s2
    for (genvar k = 0; k < 2; k++) begin : g_k
      localparam int OA = (a + k + 1) % 3;
      logic signed [UW-1:0] u;
      always_comb begin
        u = UW'(rel_r[OA]) + UW'(prod_r[a][k] >>> FRAC_BITS);
        in_box[a][k] = (u < HALF) && (nz_r[OA] ? (u >= -HALF) : (u > -HALF));
      end
    end
    assign pass[a] = ok_r[a] && in_box[a][0] && in_box[a][1];
  end

  logic              hit_nxt;
  logic [DIST_W-1:0] dist_nxt;

  always_comb begin
    hit_nxt  = 1'b1;
    dist_nxt = '0;
    if (pass[0]) begin
      dist_nxt = t_r[0];
    end else if (pass[1]) begin
      dist_nxt = t_r[1];
    end else if (pass[2]) begin
      dist_nxt = t_r[2];
    end else begin
      hit_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r      <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1_r      <= valid_i;
      out_valid <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_hit      <= hit_nxt;
      out_distance <= dist_nxt;
    end
  end

endmodule

### dv/tb_ray_voxel_exit_intersect.sv
`timescale 1ns / 1ps
// Self-checking testbench for ray_voxel_exit_intersect.
// Needs rvx_pkg and the block; predicts the exit face of each ray in Q15.16.
module tb_ray_voxel_exit_intersect;
  import rvx_pkg::*;

  localparam int FB        = FRAC_BITS_DEF;
  localparam int N_RANDOM  = 500;
  localparam int MAX_CYC   = 400000;
  localparam int LATENCY   = 34;
  localparam logic signed [63:0] HALF = 64'sd1 <<< (FB - 1);
  localparam logic signed [63:0] ONE  = 64'sd1 <<< FB;

  typedef struct {
    logic [VOXEL_W-1:0] vox[3];
    logic signed [DATA_W-1:0] org[3];
    logic signed [DATA_W-1:0] dir[3];
  } ray_t;

  typedef struct {
    logic              hit;
    logic [DIST_W-1:0] distance;
  } exit_t;

  // directed row: chk set when the result is typed in
  typedef struct {
    ray_t  ray;
    logic  chk;
    exit_t res;
  } row_t;

  logic clk = 0, rst_n = 0;
  logic in_valid = 0, in_stall;
  logic [VOXEL_W-1:0] in_voxel_x = '0, in_voxel_y = '0, in_voxel_z = '0;
  logic signed [DATA_W-1:0] in_origin_x = '0, in_origin_y = '0, in_origin_z = '0;
  logic signed [DATA_W-1:0] in_dir_x = '0, in_dir_y = '0, in_dir_z = '0;
  logic out_valid, out_stall = 1;
  logic out_hit;
  logic [DIST_W-1:0] out_distance;

  exit_t exits_pending[$];
  int    n_mismatch = 0, n_checked = 0, n_hits = 0, n_sent = 0;
  int    cycles = 0;
  bit    hold_off = 0, no_idle = 0;
  row_t  rows[$];

  ray_voxel_exit_intersect dut (
    .clk, .rst_n, .in_valid, .in_stall,
    .in_voxel_x, .in_voxel_y, .in_voxel_z,
    .in_origin_x, .in_origin_y, .in_origin_z,
    .in_dir_x, .in_dir_y, .in_dir_z,
    .out_valid, .out_stall, .out_hit, .out_distance
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYC) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic logic signed [63:0] floor_q(logic signed [63:0] p);
    return p >>> FB;
  endfunction

  function automatic logic in_cell(logic [VOXEL_W-1:0] idx, logic signed [63:0] u);
    if (idx == 0) return u > -HALF && u < HALF;
    return u >= -HALF && u < HALF;
  endfunction

  // exit distance: first axis whose face passes the range and containment tests
  function automatic exit_t exit_face(ray_t r);
    exit_t e;
    logic signed [63:0] rel[3], d[3], num, t, u, v;
    logic [63:0] nmag, dmag, ip, q;
    logic dneg, tneg, ok;
    int a1, a2;
    e.hit = 0;
    e.distance = '0;
    for (int m = 0; m < 3; m++) begin
      rel[m] = 64'(r.org[m]) - (64'(r.vox[m]) <<< FB);
      d[m] = 64'(r.dir[m]);
    end
    for (int a = 0; a < 3; a++) begin
      a1 = (a + 1) % 3;
      a2 = (a + 2) % 3;
      if (d[a] == 0) continue;
      dneg = d[a] < 0;
      num = dneg ? (-HALF - rel[a]) : (HALF - rel[a]);
      nmag = num < 0 ? -num : num;
      dmag = dneg ? -d[a] : d[a];
      ip = nmag / dmag;
      if (ip > (64'h7FFF_FFFF >> FB)) q = 64'h7FFF_FFFF;
      else begin
        q = (ip << FB) + (((nmag % dmag) << FB) / dmag);
        if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
      end
      tneg = (q != 0) && ((num < 0) != dneg);
      ok = (dneg && r.vox[a] != 0) ? !tneg : (!tneg && q != 0);
      if (!ok) continue;
      t = $signed(q);
      u = rel[a1] + floor_q(t * d[a1]);
      v = rel[a2] + floor_q(t * d[a2]);
      if (in_cell(r.vox[a1], u) && in_cell(r.vox[a2], v)) begin
        e.hit = 1;
        e.distance = q[DIST_W-1:0];
        return e;
      end
    end
    return e;
  endfunction

  function automatic logic signed [31:0] rnd_val();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $signed($urandom_range(0, 6)) - 3 <<< FB;
      2: return 32'sd0;
      3: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      default: return 32'($signed($urandom_range(0, 2 * ONE)) - ONE);
    endcase
  endfunction

  // mostly rays that start near their voxel so exits are plentiful
  function automatic ray_t rnd_ray();
    ray_t r;
    bit near;
    near = $urandom_range(0, 9) < 8;
    for (int m = 0; m < 3; m++) begin
      case ($urandom_range(0, 5))
        0: r.vox[m] = '0;
        1: r.vox[m] = '1;
        2: r.vox[m] = VOXEL_W'($urandom_range(0, 3));
        default: r.vox[m] = VOXEL_W'($urandom);
      endcase
      if (near)
        r.org[m] = DATA_W'((64'(r.vox[m]) <<< FB) + $signed($urandom_range(0, ONE)) - HALF);
      else
        r.org[m] = rnd_val();
      if (near)
        r.dir[m] = DATA_W'($signed($urandom_range(0, 4 * ONE)) - 2 * ONE);
      else
        r.dir[m] = rnd_val();
      if ($urandom_range(0, 11) == 0) r.dir[m] = 0;
    end
    return r;
  endfunction

  function automatic row_t mk(int vx, int vy, int vz, int ox, int oy, int oz,
                              int dx, int dy, int dz, logic chk, logic h, int dist_v);
    row_t w;
    w.ray.vox = '{VOXEL_W'(vx), VOXEL_W'(vy), VOXEL_W'(vz)};
    w.ray.org = '{ox, oy, oz};
    w.ray.dir = '{dx, dy, dz};
    w.chk = chk;
    w.res.hit = h;
    w.res.distance = DIST_W'(dist_v);
    return w;
  endfunction

  task automatic send(ray_t r);
    while (!no_idle && $urandom_range(0, 99) < 17) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    {in_voxel_x, in_voxel_y, in_voxel_z} <= {r.vox[0], r.vox[1], r.vox[2]};
    {in_origin_x, in_origin_y, in_origin_z} <= {r.org[0], r.org[1], r.org[2]};
    {in_dir_x, in_dir_y, in_dir_z} <= {r.dir[0], r.dir[1], r.dir[2]};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_sent++;
  endtask

  // receiver stall pattern
  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1;
    else out_stall <= hold_off || (!no_idle && $urandom_range(0, 99) < 17);
  end

  always @(posedge clk) begin
    exit_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (exits_pending.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("unexpected transaction hit=%0b dist=%h",
                                       out_hit, out_distance);
      end else begin
        want = exits_pending.pop_front();
        n_checked++;
        n_hits += out_hit;
        if (out_hit !== want.hit || out_distance !== want.distance) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("mismatch: exp hit=%0b dist=%h got hit=%0b dist=%h",
                     want.hit, want.distance, out_hit, out_distance);
        end
      end
    end
  end

  initial begin
    exit_t e;
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // axis-aligned exits, negative faces, zero index rules, extremes
    rows.push_back(mk(0, 0, 0, 0, 0, 0, 65536, 0, 0, 1, 1, 32768));
    rows.push_back(mk(0, 0, 0, 0, 0, 0, -65536, 0, 0, 1, 1, 32768));
    rows.push_back(mk(0, 0, 0, 0, 0, 0, 0, 65536, 0, 1, 1, 32768));
    rows.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, -65536, 1, 1, 32768));
    rows.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0));
    rows.push_back(mk(0, 0, 0, 32768, 0, 0, 65536, 0, 0, 0, 0, 0));
    rows.push_back(mk(5, 0, 0, 5 * 65536 - 32768, 0, 0, -65536, 0, 0, 0, 0, 0));
    rows.push_back(mk(0, 0, 0, -32768, 0, 0, -65536, 0, 0, 0, 0, 0));
    rows.push_back(mk(0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0));
    rows.push_back(mk(1023, 1023, 1023, 0, 0, 0, 65536, 65536, 65536, 0, 0, 0));
    rows.push_back(mk(1023, 1023, 1023, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                      32'h80000000, 32'h80000000, 32'h80000000, 0, 0, 0));
    rows.push_back(mk(0, 0, 0, 32'h80000000, 32'h80000000, 32'h80000000,
                      32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, 0, 0));
    rows.push_back(mk(0, 0, 0, 0, 0, 0, 65536, 65536, 0, 0, 0, 0));
    rows.push_back(mk(2, 3, 4, 131072, 196608, 262144, 30000, -20000, 10000, 0, 0, 0));
    rows.push_back(mk(0, 0, 0, 0, 0, 0, 32'h80000000, 1, -1, 0, 0, 0));
    foreach (rows[i]) begin
      e = exit_face(rows[i].ray);
      exits_pending.push_back(rows[i].chk ? rows[i].res : e);
      send(rows[i].ray);
    end
    // receiver holds off long enough to back the pipe up into the input
    fork
      begin
        hold_off = 1;
        for (int c = 0; c < 200; c++) @(posedge clk);
        hold_off = 0;
      end
      for (int i = 0; i < 80; i++) begin
        automatic ray_t r = rnd_ray();
        exits_pending.push_back(exit_face(r));
        send(r);
      end
    join
    for (int i = 0; i < N_RANDOM; i++) begin
      automatic ray_t r = rnd_ray();
      no_idle = (i >= 200 && i < 300);
      exits_pending.push_back(exit_face(r));
      send(r);
    end
    no_idle = 0;
    in_valid <= 0;
    while (exits_pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    $display("%0d rays sent, %0d exits checked, %0d hits, including a long output hold-off",
             n_sent, n_checked, n_hits);
    if (n_mismatch == 0 && exits_pending.size() == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule

### filelist.f
rtl/rvx_pkg.sv
rtl/rvx_prep.sv
rtl/rvx_div_step.sv
rtl/rvx_check.sv
rtl/ray_voxel_exit_intersect.sv
dv/tb_ray_voxel_exit_intersect.sv
